// ===== rtl/imu_motion_tilt_shock_monitor_defines.svh =====
// assertion macros used by the checker file
`ifndef IMU_MOTION_TILT_SHOCK_MONITOR_DEFINES_SVH
`define IMU_MOTION_TILT_SHOCK_MONITOR_DEFINES_SVH

// plain property, sampled on the rising edge, off while in reset
`define IMTSM_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// once cond holds, sig must not move on the next edge
`define IMTSM_ASSERT_HOLD(name, clk, rst, cond, sig, msg) \
  name: assert property (@(posedge clk) disable iff (rst) cond |=> $stable(sig)) \
    else $error(msg);

`endif

// ===== rtl/imtsm_pkg.sv =====
`default_nettype none

package imtsm_pkg;

  // parameter defaults
  localparam int AXES_DEF        = 3;
  localparam int SAMPLE_BITS_DEF = 16;

  // field widths
  localparam int OPC_W       = 2;
  localparam int ACCEL_W     = 15;
  localparam int MAG_W       = 15;
  localparam int MARGIN_W    = 15;
  localparam int HOLD_W      = 8;
  localparam int LIMIT_W     = 8;
  localparam int TAN_W       = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // tilt datapath widths
  localparam int SQ_W    = 2 * ACCEL_W - 1;
  localparam int SUM_W   = SQ_W + 1;
  localparam int PROD_W  = SUM_W + TAN_W;
  localparam int FRAC_W  = 16;

  localparam int QUEUE_DEPTH = 2;

  // opcodes
  localparam logic [OPC_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OPC_W-1:0] OP_CAL_START = 2'd1;
  localparam logic [OPC_W-1:0] OP_CAL_STOP  = 2'd2;
  localparam logic [OPC_W-1:0] OP_ENV_CLEAR = 2'd3;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SHOCK_THRESHOLD = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_MARGIN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MOTION_HOLD     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SAFE_LIMIT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_TILT_TAN_SQ     = 3'd4;

  // reset values: 2.5 g, 15 deg/s, tan^2 of about 17.7 deg
  localparam logic [MAG_W-1:0]    SHOCK_THRESHOLD_RST = 15'd2560;
  localparam logic [MARGIN_W-1:0] MOTION_MARGIN_RST   = 15'd240;
  localparam logic [HOLD_W-1:0]   MOTION_HOLD_RST     = 8'd40;
  localparam logic [LIMIT_W-1:0]  SAFE_LIMIT_RST      = 8'd10;
  localparam logic [TAN_W-1:0]    TILT_TAN_SQ_RST     = 16'd6723;

  // safe once the counter is above the limit minus this
  localparam logic [LIMIT_W+1:0]  SAFE_BACKOFF = 10'd5;

  typedef struct packed {
    logic [MAG_W-1:0]    shock_threshold;
    logic [MARGIN_W-1:0] motion_margin;
    logic [HOLD_W-1:0]   motion_hold;
    logic [LIMIT_W-1:0]  safe_limit;
    logic [TAN_W-1:0]    tilt_tan_sq;
  } cfg_t;

  // classified item as it sits in the queue (rates travel beside it)
  typedef struct packed {
    logic [OPC_W-1:0]          op;
    logic                      hit_shock;
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
    logic signed [ACCEL_W-1:0] az;
  } job_t;

  localparam int JOB_W = $bits(job_t);

endpackage

`default_nettype wire

// ===== rtl/imtsm_if.sv =====
`default_nettype none

interface imtsm_in_if #(
  parameter int SAMPLE_BITS = imtsm_pkg::SAMPLE_BITS_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic [imtsm_pkg::OPC_W-1:0]            opcode;
  logic signed [imtsm_pkg::ACCEL_W-1:0]   accel_x;
  logic signed [imtsm_pkg::ACCEL_W-1:0]   accel_y;
  logic signed [imtsm_pkg::ACCEL_W-1:0]   accel_z;
  logic [imtsm_pkg::MAG_W-1:0]            accel_mag;
  logic signed [SAMPLE_BITS-1:0]          rate_x;
  logic signed [SAMPLE_BITS-1:0]          rate_y;
  logic signed [SAMPLE_BITS-1:0]          rate_z;

  modport source (
    output valid, opcode, accel_x, accel_y, accel_z, accel_mag, rate_x, rate_y, rate_z,
    input  ready
  );
  modport sink (
    input  valid, opcode, accel_x, accel_y, accel_z, accel_mag, rate_x, rate_y, rate_z,
    output ready
  );
endinterface

interface imtsm_out_if;
  logic valid;
  logic ready;
  logic shock;
  logic moving;
  logic safe;
  logic calibrating;

  modport source (
    output valid, shock, moving, safe, calibrating,
    input  ready
  );
  modport sink (
    input  valid, shock, moving, safe, calibrating,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/imu_motion_tilt_shock_monitor.sv =====
`default_nettype none

// IMU monitor: every beat on items (a sample or an envelope command) yields exactly one
// status beat on results, in order. A front end classifies the beat and settles the shock
// test, then drops it into a two-beat queue; the execution unit behind it registers the
// squares of the three accelerations, runs the three tan^2 products through one shared
// 16x30 multiplier one after another and then updates all state in a final step, which
// waits while the output register still holds an untaken result. A command skips the
// multiplier. The execution unit takes no new item until it is done with the last one;
// that multiplier loop limits the sample stream. The output register lets the next
// item start while a result waits. Registers on cfg_write are taken at once and are
// meant to change only while nothing is in flight. There is no clearing pass; the
// block takes items right after reset.
module imu_motion_tilt_shock_monitor #(
  parameter int AXES        = imtsm_pkg::AXES_DEF,
  parameter int SAMPLE_BITS = imtsm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  imtsm_in_if.sink                                 items,
  imtsm_out_if.source                              results,
  input  wire logic                                cfg_write,
  input  wire logic [imtsm_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [imtsm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int RATES_W = AXES * SAMPLE_BITS;
  localparam int QW      = imtsm_pkg::JOB_W + RATES_W;

  imtsm_pkg::cfg_t      cfg;
  imtsm_pkg::job_t      push_job;
  imtsm_pkg::job_t      pop_job;
  logic [RATES_W-1:0]   push_rates;
  logic [RATES_W-1:0]   pop_rates;
  logic                 push_valid, push_ready;
  logic                 pop_valid, pop_ready;
  logic [QW-1:0]        pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shock_threshold <= imtsm_pkg::SHOCK_THRESHOLD_RST;
      cfg.motion_margin   <= imtsm_pkg::MOTION_MARGIN_RST;
      cfg.motion_hold     <= imtsm_pkg::MOTION_HOLD_RST;
      cfg.safe_limit      <= imtsm_pkg::SAFE_LIMIT_RST;
      cfg.tilt_tan_sq     <= imtsm_pkg::TILT_TAN_SQ_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        imtsm_pkg::REG_SHOCK_THRESHOLD: cfg.shock_threshold <= cfg_data[imtsm_pkg::MAG_W-1:0];
        imtsm_pkg::REG_MOTION_MARGIN:   cfg.motion_margin <= cfg_data[imtsm_pkg::MARGIN_W-1:0];
        imtsm_pkg::REG_MOTION_HOLD:     cfg.motion_hold   <= cfg_data[imtsm_pkg::HOLD_W-1:0];
        imtsm_pkg::REG_SAFE_LIMIT:      cfg.safe_limit    <= cfg_data[imtsm_pkg::LIMIT_W-1:0];
        imtsm_pkg::REG_TILT_TAN_SQ:     cfg.tilt_tan_sq   <= cfg_data[imtsm_pkg::TAN_W-1:0];
        default: cfg.tilt_tan_sq <= cfg.tilt_tan_sq;
      endcase
    end
  end

  imtsm_front #(
    .AXES        (AXES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .items           (items),
    .shock_threshold (cfg.shock_threshold),
    .push_valid      (push_valid),
    .push_ready      (push_ready),
    .push_job        (push_job),
    .push_rates      (push_rates)
  );

  imtsm_queue #(
    .WIDTH (QW),
    .DEPTH (imtsm_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_job, push_rates}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_job   = pop_data[QW-1 -: imtsm_pkg::JOB_W];
  assign pop_rates = pop_data[RATES_W-1:0];

  imtsm_back #(
    .AXES        (AXES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .pop_rates (pop_rates),
    .results   (results)
  );

endmodule

`default_nettype wire

// ===== rtl/imtsm_front.sv =====
`default_nettype none

module imtsm_front #(
  parameter int AXES        = imtsm_pkg::AXES_DEF,
  parameter int SAMPLE_BITS = imtsm_pkg::SAMPLE_BITS_DEF
) (
  imtsm_in_if.sink                          items,
  input  wire logic [imtsm_pkg::MAG_W-1:0]  shock_threshold,
  output logic                              push_valid,
  input  wire logic                         push_ready,
  output imtsm_pkg::job_t                   push_job,
  output logic [AXES*SAMPLE_BITS-1:0]       push_rates
);

  logic signed [SAMPLE_BITS-1:0] rate_all [3];

  assign items.ready = push_ready;
  assign push_valid  = items.valid;

  // shock test is settled here so the queue never carries the magnitude
  assign push_job.op        = items.opcode;
  assign push_job.hit_shock = (items.opcode == imtsm_pkg::OP_SAMPLE) &&
                              (items.accel_mag > shock_threshold);
  assign push_job.ax        = items.accel_x;
  assign push_job.ay        = items.accel_y;
  assign push_job.az        = items.accel_z;

  assign rate_all[0] = items.rate_x;
  assign rate_all[1] = items.rate_y;
  assign rate_all[2] = items.rate_z;

  for (genvar i = 0; i < AXES; i++) begin : g_rate
    assign push_rates[i*SAMPLE_BITS +: SAMPLE_BITS] = rate_all[i];
  end

endmodule

`default_nettype wire

// ===== rtl/imtsm_queue.sv =====
`default_nettype none

module imtsm_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = imtsm_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output logic                  push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  wire logic             pop_ready,
  output logic [WIDTH-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push_fire;
  logic             pop_fire;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) wr_ptr <= ptr_inc(wr_ptr);
      if (pop_fire)  rd_ptr <= ptr_inc(rd_ptr);
      if (push_fire && !pop_fire) count <= count + 1'b1;
      else if (pop_fire && !push_fire) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) slots[wr_ptr] <= push_data;
  end

endmodule

`default_nettype wire

// ===== rtl/imtsm_back.sv =====
`default_nettype none

module imtsm_back #(
  parameter int AXES        = imtsm_pkg::AXES_DEF,
  parameter int SAMPLE_BITS = imtsm_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire imtsm_pkg::cfg_t              cfg,
  input  wire logic                         pop_valid,
  output logic                              pop_ready,
  input  wire imtsm_pkg::job_t              pop_job,
  input  wire logic [AXES*SAMPLE_BITS-1:0]  pop_rates,
  imtsm_out_if.source                       results
);

  localparam int EXT_W = ((SAMPLE_BITS > imtsm_pkg::MARGIN_W) ?
                          SAMPLE_BITS : imtsm_pkg::MARGIN_W) + 2;
  localparam int HW = imtsm_pkg::HOLD_W;
  localparam int LW = imtsm_pkg::LIMIT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  localparam logic [1:0] STEP_X    = 2'd0;
  localparam logic [1:0] STEP_Y    = 2'd1;
  localparam logic [1:0] STEP_LAST = 2'd2;

  // sequencer
  logic [1:0] state;
  logic [1:0] mul_idx;

  // item under work
  imtsm_pkg::job_t                  job;
  logic [AXES*SAMPLE_BITS-1:0]      rates_r;
  logic [imtsm_pkg::SQ_W-1:0]       x2, y2, z2;
  logic [imtsm_pkg::PROD_W-1:0]     prod;
  logic                             tilt_ok;

  // monitor state
  logic                             shock_latch;
  logic                             cal_active;
  logic signed [SAMPLE_BITS-1:0]    env_min   [AXES];
  logic signed [SAMPLE_BITS-1:0]    env_max   [AXES];
  logic signed [SAMPLE_BITS-1:0]    last_rate [AXES];
  logic [HW-1:0]                    move_count;
  logic [LW-1:0]                    safe_count;

  logic                             shock_latch_next;
  logic                             cal_active_next;
  logic signed [SAMPLE_BITS-1:0]    env_min_next   [AXES];
  logic signed [SAMPLE_BITS-1:0]    env_max_next   [AXES];
  logic signed [SAMPLE_BITS-1:0]    last_rate_next [AXES];
  logic [HW-1:0]                    move_count_next;
  logic [LW-1:0]                    safe_count_next;

  // output register
  logic out_valid;
  logic out_shock;
  logic out_moving;
  logic out_safe;
  logic out_calibrating;

  // datapath
  logic signed [2*imtsm_pkg::ACCEL_W-1:0] ax_sq, ay_sq, az_sq;
  logic [imtsm_pkg::SUM_W-1:0]      mul_opnd;
  logic [imtsm_pkg::PROD_W-1:0]     prod_next;
  logic [1:0]                       cmp_idx;
  logic [imtsm_pkg::PROD_W-1:0]     cmp_lhs;
  logic                             cmp_lt;
  logic                             tilt_pass;
  logic signed [SAMPLE_BITS-1:0]    rate_v [AXES];
  logic signed [SAMPLE_BITS-1:0]    wmax_v [AXES];
  logic signed [SAMPLE_BITS-1:0]    wmin_v [AXES];
  logic [AXES-1:0]                  axis_hit;
  logic                             moving_hit;
  logic [HW-1:0]                    mc_step;
  logic [HW-1:0]                    mc_clamp;
  logic [LW:0]                      sc_step;
  logic [LW-1:0]                    sc_clamp;
  logic                             fin_go;
  logic signed [EXT_W-1:0]          margin_ext;

  assign pop_ready = (state == ST_IDLE);
  assign fin_go    = (state == ST_FIN) && (!out_valid || results.ready);

  assign ax_sq = pop_job.ax * pop_job.ax;
  assign ay_sq = pop_job.ay * pop_job.ay;
  assign az_sq = pop_job.az * pop_job.az;

  // one shared tan^2 multiplier, one right-hand side per step
  always_comb begin
    case (mul_idx)
      STEP_X:  mul_opnd = imtsm_pkg::SUM_W'(y2) + imtsm_pkg::SUM_W'(z2);
      STEP_Y:  mul_opnd = imtsm_pkg::SUM_W'(x2) + imtsm_pkg::SUM_W'(z2);
      default: mul_opnd = imtsm_pkg::SUM_W'(z2);
    endcase
  end

  assign prod_next = cfg.tilt_tan_sq * mul_opnd;

  // compare runs one step behind the multiplier
  assign cmp_idx = (state == ST_FIN) ? STEP_LAST : mul_idx - 2'd1;

  always_comb begin
    case (cmp_idx)
      STEP_X:  cmp_lhs = imtsm_pkg::PROD_W'({x2, {imtsm_pkg::FRAC_W{1'b0}}});
      STEP_Y:  cmp_lhs = imtsm_pkg::PROD_W'({y2, {imtsm_pkg::FRAC_W{1'b0}}});
      default: cmp_lhs = imtsm_pkg::PROD_W'({imtsm_pkg::SUM_W'(x2) + imtsm_pkg::SUM_W'(y2),
                                             {imtsm_pkg::FRAC_W{1'b0}}});
    endcase
  end

  assign cmp_lt    = cmp_lhs < prod;
  assign tilt_pass = tilt_ok && cmp_lt;

  assign margin_ext = $signed({{(EXT_W-imtsm_pkg::MARGIN_W){1'b0}}, cfg.motion_margin});

  for (genvar i = 0; i < AXES; i++) begin : g_axis
    assign rate_v[i] = $signed(rates_r[i*SAMPLE_BITS +: SAMPLE_BITS]);
    // envelope widens first, then the margin test sees the widened bounds
    assign wmax_v[i] = (cal_active && (rate_v[i] > env_max[i])) ? rate_v[i] : env_max[i];
    assign wmin_v[i] = (cal_active && (rate_v[i] < env_min[i])) ? rate_v[i] : env_min[i];
    assign axis_hit[i] = (EXT_W'(rate_v[i]) > (EXT_W'(wmax_v[i]) + margin_ext)) ||
                         (EXT_W'(rate_v[i]) < (EXT_W'(wmin_v[i]) - margin_ext));
  end

  assign moving_hit = |axis_hit;

  assign mc_step  = moving_hit ? cfg.motion_hold :
                    (move_count != '0) ? move_count - 1'b1 : '0;
  assign mc_clamp = (mc_step > cfg.motion_hold) ? cfg.motion_hold : mc_step;

  // one spare bit so a full counter at a limit of 255 does not wrap
  assign sc_step  = tilt_pass ? {1'b0, safe_count} + 1'b1 :
                    (safe_count != '0) ? {1'b0, safe_count} - 1'b1 : '0;
  assign sc_clamp = (sc_step > {1'b0, cfg.safe_limit}) ? cfg.safe_limit : sc_step[LW-1:0];

  always_comb begin
    shock_latch_next = shock_latch;
    cal_active_next  = cal_active;
    env_min_next     = env_min;
    env_max_next     = env_max;
    last_rate_next   = last_rate;
    move_count_next  = move_count;
    safe_count_next  = safe_count;
    case (job.op)
      imtsm_pkg::OP_SAMPLE: begin
        shock_latch_next = shock_latch | job.hit_shock;
        last_rate_next   = rate_v;
        env_max_next     = wmax_v;
        env_min_next     = wmin_v;
        move_count_next  = mc_clamp;
        safe_count_next  = sc_clamp;
      end
      imtsm_pkg::OP_CAL_START: begin
        env_min_next    = last_rate;
        env_max_next    = last_rate;
        cal_active_next = 1'b1;
      end
      imtsm_pkg::OP_CAL_STOP: begin
        cal_active_next = 1'b0;
      end
      imtsm_pkg::OP_ENV_CLEAR: begin
        for (int i = 0; i < AXES; i++) begin
          env_min_next[i] = '0;
          env_max_next[i] = '0;
        end
        cal_active_next = 1'b0;
      end
      default: begin
        cal_active_next = cal_active;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      mul_idx   <= STEP_X;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            mul_idx <= STEP_X;
            state   <= (pop_job.op == imtsm_pkg::OP_SAMPLE) ? ST_MUL : ST_FIN;
          end
        end
        ST_MUL: begin
          mul_idx <= mul_idx + 2'd1;
          if (mul_idx == STEP_LAST) state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_go) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
      if (fin_go) out_valid <= 1'b1;
      else if (results.ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      job     <= pop_job;
      rates_r <= pop_rates;
      x2      <= imtsm_pkg::SQ_W'(ax_sq);
      y2      <= imtsm_pkg::SQ_W'(ay_sq);
      z2      <= imtsm_pkg::SQ_W'(az_sq);
      tilt_ok <= 1'b1;
    end
    if (state == ST_MUL) begin
      prod <= prod_next;
      if (mul_idx != STEP_X) tilt_ok <= tilt_pass;
    end
    if (fin_go) begin
      out_shock       <= shock_latch_next;
      out_moving      <= (move_count_next != '0);
      out_safe        <= ({2'b00, safe_count_next} + imtsm_pkg::SAFE_BACKOFF) >
                         {2'b00, cfg.safe_limit};
      out_calibrating <= cal_active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shock_latch <= 1'b0;
      cal_active  <= 1'b0;
      move_count  <= '0;
      safe_count  <= imtsm_pkg::SAFE_LIMIT_RST;
      for (int i = 0; i < AXES; i++) begin
        env_min[i]   <= '0;
        env_max[i]   <= '0;
        last_rate[i] <= '0;
      end
    end else if (fin_go) begin
      shock_latch <= shock_latch_next;
      cal_active  <= cal_active_next;
      move_count  <= move_count_next;
      safe_count  <= safe_count_next;
      env_min     <= env_min_next;
      env_max     <= env_max_next;
      last_rate   <= last_rate_next;
    end
  end

  assign results.valid       = out_valid;
  assign results.shock       = out_shock;
  assign results.moving      = out_moving;
  assign results.safe        = out_safe;
  assign results.calibrating = out_calibrating;

endmodule

`default_nettype wire

// ===== rtl/imtsm_checker.sv =====
`default_nettype none

`include "imu_motion_tilt_shock_monitor_defines.svh"

module imtsm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_shock,
  input wire logic out_moving,
  input wire logic out_safe,
  input wire logic out_calibrating
);

  // beats in flight: queue, execution unit and output register
  logic [2:0] pending;
  logic       seen_shock;
  logic       in_beat;
  logic       out_beat;
  logic [3:0] out_status;

  assign in_beat    = in_valid && in_ready;
  assign out_beat   = out_valid && out_ready;
  assign out_status = {out_shock, out_moving, out_safe, out_calibrating};

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      seen_shock <= 1'b0;
    end else begin
      if (in_beat && !out_beat) pending <= pending + 1'b1;
      else if (out_beat && !in_beat) pending <= pending - 1'b1;
      if (out_beat && out_shock) seen_shock <= 1'b1;
    end
  end

  `IMTSM_ASSERT(a_out_held, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `IMTSM_ASSERT_HOLD(a_out_stable, clk, rst, out_valid && !out_ready, out_status, "result payload moved while stalled")
  `IMTSM_ASSERT(a_no_orphan, clk, rst, out_valid |-> pending != 3'd0, "result with no item in flight")
  `IMTSM_ASSERT(a_shock_sticky, clk, rst, out_valid && seen_shock |-> out_shock, "shock flag fell after being reported")

endmodule

bind imu_motion_tilt_shock_monitor imtsm_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (items.valid),
  .in_ready        (items.ready),
  .out_valid       (results.valid),
  .out_ready       (results.ready),
  .out_shock       (results.shock),
  .out_moving      (results.moving),
  .out_safe        (results.safe),
  .out_calibrating (results.calibrating)
);

`default_nettype wire

// ===== dv/imu_motion_tilt_shock_monitor_test.sv =====
`timescale 1ns / 1ps

module imu_motion_tilt_shock_monitor_test;

  localparam int RATE_W = imtsm_pkg::SAMPLE_BITS_DEF;
  localparam int RATE_MAX = (1 << (RATE_W - 1)) - 1;
  localparam int RATE_MIN = -(1 << (RATE_W - 1));
  localparam int ACCEL_MAX = (1 << (imtsm_pkg::ACCEL_W - 1)) - 1;
  localparam int ACCEL_MIN = -(1 << (imtsm_pkg::ACCEL_W - 1));
  localparam int MAG_MAX = (1 << imtsm_pkg::MAG_W) - 1;
  localparam int MARGIN_MAX = (1 << imtsm_pkg::MARGIN_W) - 1;
  localparam int HOLD_MAX = (1 << imtsm_pkg::HOLD_W) - 1;
  localparam int LIMIT_MAX = (1 << imtsm_pkg::LIMIT_W) - 1;
  localparam int TAN_MAX = (1 << imtsm_pkg::TAN_W) - 1;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_LIMIT = 10;

  typedef enum int {AIM_ABOVE, AIM_BELOW, AIM_INSIDE, AIM_SMALL, AIM_ANY} rate_aim_t;
  typedef enum int {STYLE_QUIET, STYLE_MIXED, STYLE_CAL} sample_style_t;

  typedef struct {
    logic [imtsm_pkg::OPC_W-1:0]          opcode;
    logic signed [imtsm_pkg::ACCEL_W-1:0] ax;
    logic signed [imtsm_pkg::ACCEL_W-1:0] ay;
    logic signed [imtsm_pkg::ACCEL_W-1:0] az;
    logic [imtsm_pkg::MAG_W-1:0]          mag;
    logic signed [RATE_W-1:0]             rx;
    logic signed [RATE_W-1:0]             ry;
    logic signed [RATE_W-1:0]             rz;
  } imu_beat_t;

  typedef struct packed {
    logic shock;
    logic moving;
    logic safe;
    logic calibrating;
  } status_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [imtsm_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [imtsm_pkg::CFG_DATA_W-1:0] cfg_data;

  imtsm_in_if items_if ();
  imtsm_out_if results_if ();

  imu_motion_tilt_shock_monitor DUT (
    .clk      (clk),
    .rst      (rst),
    .items    (items_if),
    .results  (results_if),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  imu_beat_t pending_beats[$];
  status_t status_expected[$];
  imu_beat_t driven_beat;
  imu_beat_t taken_beat;
  status_t got_status;
  status_t want_status;

  int sender_idle_pct;
  int recv_stall_pct;
  int mismatch_count;
  int beats_queued;
  bit no_shock;
  int hold_off_left;
  int holdoffs_asked;
  int holdoffs_taken;

  // mirror of the monitor registers and state
  int thr_cfg, margin_cfg, hold_cfg, limit_cfg, tan_cfg;
  bit shock_seen, cal_on;
  int env_lo[3], env_hi[3], prev_rate[3];
  int move_left, safe_level;

  function automatic status_t predict_status(imu_beat_t b);
    status_t s;
    int r[3];
    longint x2, y2, z2, t;
    bit moved, level;
    r[0] = b.rx;
    r[1] = b.ry;
    r[2] = b.rz;
    case (b.opcode)
      imtsm_pkg::OP_SAMPLE: begin
        if (int'(b.mag) > thr_cfg) shock_seen = 1'b1;
        moved = 1'b0;
        for (int a = 0; a < 3; a++) begin
          prev_rate[a] = r[a];
          if (cal_on) begin
            if (r[a] > env_hi[a]) env_hi[a] = r[a];
            if (r[a] < env_lo[a]) env_lo[a] = r[a];
          end
          if (r[a] > env_hi[a] + margin_cfg || r[a] < env_lo[a] - margin_cfg) moved = 1'b1;
        end
        if (moved) move_left = hold_cfg;
        else if (move_left != 0) move_left--;
        if (move_left > hold_cfg) move_left = hold_cfg;
        x2 = longint'(b.ax) * longint'(b.ax);
        y2 = longint'(b.ay) * longint'(b.ay);
        z2 = longint'(b.az) * longint'(b.az);
        t = tan_cfg;
        // tan^2 form of the tilt test, a zero right side never passes
        level = ((x2 << 16) < t * (y2 + z2)) && ((y2 << 16) < t * (x2 + z2)) &&
                (((x2 + y2) << 16) < t * z2);
        if (level) safe_level++;
        else if (safe_level != 0) safe_level--;
        if (safe_level > limit_cfg) safe_level = limit_cfg;
      end
      imtsm_pkg::OP_CAL_START: begin
        for (int a = 0; a < 3; a++) begin
          env_lo[a] = prev_rate[a];
          env_hi[a] = prev_rate[a];
        end
        cal_on = 1'b1;
      end
      imtsm_pkg::OP_CAL_STOP: cal_on = 1'b0;
      imtsm_pkg::OP_ENV_CLEAR: begin
        for (int a = 0; a < 3; a++) begin
          env_lo[a] = 0;
          env_hi[a] = 0;
        end
        cal_on = 1'b0;
      end
    endcase
    s.shock = shock_seen;
    s.moving = (move_left != 0);
    s.safe = (safe_level > limit_cfg - int'(imtsm_pkg::SAFE_BACKOFF));
    s.calibrating = cal_on;
    return s;
  endfunction

  function automatic imu_beat_t fixed_beat(logic [imtsm_pkg::OPC_W-1:0] op,
                                           int ax, int ay, int az,
                                           int mag, int rx, int ry, int rz);
    imu_beat_t b;
    b.opcode = op;
    b.ax = imtsm_pkg::ACCEL_W'(ax);
    b.ay = imtsm_pkg::ACCEL_W'(ay);
    b.az = imtsm_pkg::ACCEL_W'(az);
    b.mag = imtsm_pkg::MAG_W'(mag);
    b.rx = RATE_W'(rx);
    b.ry = RATE_W'(ry);
    b.rz = RATE_W'(rz);
    return b;
  endfunction

  function automatic logic signed [RATE_W-1:0] aim_rate(int a, rate_aim_t aim);
    int lo, hi, v;
    lo = env_lo[a] - margin_cfg;
    hi = env_hi[a] + margin_cfg;
    case (aim)
      AIM_ABOVE:  v = hi + int'($urandom_range(4)) - 2;
      AIM_BELOW:  v = lo + int'($urandom_range(4)) - 2;
      AIM_INSIDE: v = lo + int'($urandom_range(hi - lo));
      AIM_SMALL:  v = int'($urandom_range(2000)) - 1000;
      default:    v = int'($urandom_range(RATE_MAX - RATE_MIN)) + RATE_MIN;
    endcase
    if (v > RATE_MAX) v = RATE_MAX;
    if (v < RATE_MIN) v = RATE_MIN;
    return RATE_W'(v);
  endfunction

  function automatic logic signed [imtsm_pkg::ACCEL_W-1:0] extreme_accel();
    int v;
    case ($urandom_range(4))
      0: v = ACCEL_MIN;
      1: v = ACCEL_MAX;
      2: v = 0;
      3: v = 1;
      default: v = -1;
    endcase
    return imtsm_pkg::ACCEL_W'(v);
  endfunction

  function automatic imu_beat_t make_beat(logic [imtsm_pkg::OPC_W-1:0] op,
                                          sample_style_t style);
    imu_beat_t b;
    int pick, spread, v;
    b.opcode = op;
    b.ax = imtsm_pkg::ACCEL_W'($urandom);
    b.ay = imtsm_pkg::ACCEL_W'($urandom);
    b.az = imtsm_pkg::ACCEL_W'($urandom);
    b.mag = imtsm_pkg::MAG_W'($urandom);
    b.rx = RATE_W'($urandom);
    b.ry = RATE_W'($urandom);
    b.rz = RATE_W'($urandom);
    if (op != imtsm_pkg::OP_SAMPLE) return b;
    pick = $urandom_range(99);
    if (pick < 55) begin
      // near upright, tilt spread straddles the limit
      v = $urandom_range(1400, 600);
      b.az = imtsm_pkg::ACCEL_W'($urandom_range(1) ? -v : v);
      spread = $urandom_range(700, 50);
      b.ax = imtsm_pkg::ACCEL_W'(int'($urandom_range(2 * spread)) - spread);
      b.ay = imtsm_pkg::ACCEL_W'(int'($urandom_range(2 * spread)) - spread);
    end else if (pick < 88 && pick >= 75) begin
      b.ax = imtsm_pkg::ACCEL_W'(int'($urandom_range(2000)) - 1000);
      b.ay = imtsm_pkg::ACCEL_W'(int'($urandom_range(2000)) - 1000);
      b.az = imtsm_pkg::ACCEL_W'(int'($urandom_range(2000)) - 1000);
      case ($urandom_range(3))
        0: begin b.ax = '0; b.ay = '0; b.az = '0; end
        1: b.az = '0;
        2: begin b.ay = '0; b.az = '0; end
        default: begin b.ax = '0; b.az = '0; end
      endcase
    end else if (pick >= 88) begin
      b.ax = extreme_accel();
      b.ay = extreme_accel();
      b.az = extreme_accel();
    end
    if ($urandom_range(9) < 3) begin
      v = thr_cfg + 1 - int'($urandom_range(2));
      if (v > MAG_MAX) v = MAG_MAX;
      if (v < 0) v = 0;
      b.mag = imtsm_pkg::MAG_W'(v);
    end
    if (no_shock && int'(b.mag) > thr_cfg) b.mag = imtsm_pkg::MAG_W'(thr_cfg);
    case (style)
      STYLE_QUIET: begin
        b.rx = aim_rate(0, AIM_INSIDE);
        b.ry = aim_rate(1, AIM_INSIDE);
        b.rz = aim_rate(2, AIM_INSIDE);
      end
      STYLE_CAL: begin
        b.rx = aim_rate(0, AIM_SMALL);
        b.ry = aim_rate(1, AIM_SMALL);
        b.rz = aim_rate(2, AIM_SMALL);
      end
      default: begin
        b.rx = aim_rate(0, rate_aim_t'($urandom_range(4)));
        b.ry = aim_rate(1, rate_aim_t'($urandom_range(4)));
        b.rz = aim_rate(2, rate_aim_t'($urandom_range(4)));
      end
    endcase
    return b;
  endfunction

  // keep the queue short so rate aiming sees an up to date envelope
  task automatic queue_next(logic [imtsm_pkg::OPC_W-1:0] op, sample_style_t style);
    while (pending_beats.size() > 2) @(posedge clk);
    pending_beats.push_back(make_beat(op, style));
    beats_queued++;
  endtask

  task automatic add_random(int count);
    int goal, pick, n, quiet_pct;
    goal = beats_queued + count;
    while (beats_queued < goal) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        case ($urandom_range(2))
          0: queue_next(imtsm_pkg::OP_CAL_START, STYLE_MIXED);
          1: queue_next(imtsm_pkg::OP_CAL_STOP, STYLE_MIXED);
          default: queue_next(imtsm_pkg::OP_ENV_CLEAR, STYLE_MIXED);
        endcase
      end else if (pick < 45) begin
        if ($urandom_range(1)) queue_next(imtsm_pkg::OP_ENV_CLEAR, STYLE_MIXED);
        queue_next(imtsm_pkg::OP_CAL_START, STYLE_MIXED);
        n = $urandom_range(5, 1);
        repeat (n) queue_next(imtsm_pkg::OP_SAMPLE, STYLE_CAL);
        // now and then calibration is left running
        if ($urandom_range(9) != 0) queue_next(imtsm_pkg::OP_CAL_STOP, STYLE_MIXED);
        n = $urandom_range(12, 3);
        repeat (n)
          queue_next(imtsm_pkg::OP_SAMPLE, $urandom_range(1) ? STYLE_QUIET : STYLE_MIXED);
      end else begin
        n = $urandom_range(24, 4);
        quiet_pct = $urandom_range(100);
        repeat (n)
          queue_next(imtsm_pkg::OP_SAMPLE,
                     int'($urandom_range(99)) < quiet_pct ? STYLE_QUIET : STYLE_MIXED);
      end
    end
  endtask

  task automatic write_reg(logic [imtsm_pkg::CFG_INDEX_W-1:0] idx, int value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= imtsm_pkg::CFG_DATA_W'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      imtsm_pkg::REG_SHOCK_THRESHOLD: thr_cfg = value & MAG_MAX;
      imtsm_pkg::REG_MOTION_MARGIN:   margin_cfg = value & MARGIN_MAX;
      imtsm_pkg::REG_MOTION_HOLD:     hold_cfg = value & HOLD_MAX;
      imtsm_pkg::REG_SAFE_LIMIT:      limit_cfg = value & LIMIT_MAX;
      imtsm_pkg::REG_TILT_TAN_SQ:     tan_cfg = value & TAN_MAX;
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || items_if.valid || status_expected.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      items_if.valid <= 1'b0;
    end else if (!items_if.valid || items_if.ready) begin
      if (pending_beats.size() != 0 && int'($urandom_range(99)) >= sender_idle_pct) begin
        driven_beat = pending_beats.pop_front();
        items_if.valid <= 1'b1;
        items_if.opcode <= driven_beat.opcode;
        items_if.accel_x <= driven_beat.ax;
        items_if.accel_y <= driven_beat.ay;
        items_if.accel_z <= driven_beat.az;
        items_if.accel_mag <= driven_beat.mag;
        items_if.rate_x <= driven_beat.rx;
        items_if.rate_y <= driven_beat.ry;
        items_if.rate_z <= driven_beat.rz;
      end else begin
        items_if.valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      hold_off_left <= 0;
      holdoffs_taken <= 0;
    end else if (hold_off_left != 0) begin
      hold_off_left <= hold_off_left - 1;
    end else if (holdoffs_taken != holdoffs_asked) begin
      hold_off_left <= HOLD_OFF_CYCLES;
      holdoffs_taken <= holdoffs_taken + 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
    end else begin
      results_if.ready <= (hold_off_left == 0) && (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // accepted input beat: predict its status
  always @(posedge clk) begin
    if (!rst && items_if.valid && items_if.ready) begin
      taken_beat.opcode = items_if.opcode;
      taken_beat.ax = items_if.accel_x;
      taken_beat.ay = items_if.accel_y;
      taken_beat.az = items_if.accel_z;
      taken_beat.mag = items_if.accel_mag;
      taken_beat.rx = items_if.rate_x;
      taken_beat.ry = items_if.rate_y;
      taken_beat.rz = items_if.rate_z;
      status_expected.push_back(predict_status(taken_beat));
    end
  end

  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) begin
      got_status.shock = results_if.shock;
      got_status.moving = results_if.moving;
      got_status.safe = results_if.safe;
      got_status.calibrating = results_if.calibrating;
      if (status_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("status beat with nothing pending: shock %b moving %b safe %b cal %b",
                   got_status.shock, got_status.moving, got_status.safe,
                   got_status.calibrating);
      end else begin
        want_status = status_expected.pop_front();
        if (got_status.shock !== want_status.shock || got_status.moving !== want_status.moving ||
            got_status.safe !== want_status.safe ||
            got_status.calibrating !== want_status.calibrating) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("status mismatch at %0t: expected %b%b%b%b got %b%b%b%b (shock moving safe cal)",
                     $realtime, want_status.shock, want_status.moving, want_status.safe,
                     want_status.calibrating, got_status.shock, got_status.moving,
                     got_status.safe, got_status.calibrating);
        end
      end
    end
  end

  initial begin
    #(2_000_000);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    items_if.valid = 1'b0;
    items_if.opcode = imtsm_pkg::OP_SAMPLE;
    items_if.accel_x = '0;
    items_if.accel_y = '0;
    items_if.accel_z = '0;
    items_if.accel_mag = '0;
    items_if.rate_x = '0;
    items_if.rate_y = '0;
    items_if.rate_z = '0;
    results_if.ready = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    mismatch_count = 0;
    beats_queued = 0;
    holdoffs_asked = 0;
    no_shock = 1'b1;
    thr_cfg = imtsm_pkg::SHOCK_THRESHOLD_RST;
    margin_cfg = imtsm_pkg::MOTION_MARGIN_RST;
    hold_cfg = imtsm_pkg::MOTION_HOLD_RST;
    limit_cfg = imtsm_pkg::SAFE_LIMIT_RST;
    tan_cfg = imtsm_pkg::TILT_TAN_SQ_RST;
    shock_seen = 1'b0;
    cal_on = 1'b0;
    for (int a = 0; a < 3; a++) begin
      env_lo[a] = 0;
      env_hi[a] = 0;
      prev_rate[a] = 0;
    end
    move_left = 0;
    safe_level = imtsm_pkg::SAFE_LIMIT_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // zero vector, extremes, zero denominators
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, ACCEL_MAX, ACCEL_MIN, ACCEL_MAX,
                                       imtsm_pkg::SHOCK_THRESHOLD_RST,
                                       RATE_MAX, RATE_MIN, RATE_MAX));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, ACCEL_MIN, ACCEL_MAX, ACCEL_MIN, 0,
                                       RATE_MIN, RATE_MAX, RATE_MIN));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 1024, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 1024, 0, 0, 1024, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 300, 0, 300, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 100, 100, 0, 141, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, -1, 1, 0, 0, 0));
    // margin edges around the cleared envelope
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 1024, 240, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 1024, 241, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 1024, 0, -240, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 1024, 0, 0, -241));
    // calibration, restart, stop, clear
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_CAL_START, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 50, 0, 1000, 1000,
                                       500, -500, 100));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 60, 1000, 1000,
                                       -300, 700, -1000));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_CAL_START, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_CAL_STOP, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1000, 1000,
                                       -60, 940, -1240));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1000, 1000,
                                       -541, 700, -1000));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_CAL_STOP, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_ENV_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_CAL_START, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_ENV_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 1024, 0, 0, 0));
    add_random(206);
    wait_drained();

    // shock threshold at its top, other registers at their low extremes, sender mostly idle
    write_reg(imtsm_pkg::REG_SHOCK_THRESHOLD, MAG_MAX);
    write_reg(imtsm_pkg::REG_MOTION_MARGIN, 0);
    write_reg(imtsm_pkg::REG_MOTION_HOLD, 1);
    write_reg(imtsm_pkg::REG_SAFE_LIMIT, int'(imtsm_pkg::SAFE_BACKOFF));
    write_reg(imtsm_pkg::REG_TILT_TAN_SQ, 0);
    sender_idle_pct = 85;
    add_random(206);
    wait_drained();

    // other extremes, shock may latch from here on
    write_reg(imtsm_pkg::REG_SHOCK_THRESHOLD, 0);
    write_reg(imtsm_pkg::REG_MOTION_MARGIN, MARGIN_MAX);
    write_reg(imtsm_pkg::REG_MOTION_HOLD, HOLD_MAX);
    write_reg(imtsm_pkg::REG_SAFE_LIMIT, LIMIT_MAX);
    write_reg(imtsm_pkg::REG_TILT_TAN_SQ, TAN_MAX);
    no_shock = 1'b0;
    sender_idle_pct = 0;
    recv_stall_pct = 85;
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 0, 0, 0, 0));
    pending_beats.push_back(fixed_beat(imtsm_pkg::OP_SAMPLE, 0, 0, 1024, 1, 0, 0, 0));
    add_random(204);
    wait_drained();

    write_reg(imtsm_pkg::REG_SHOCK_THRESHOLD, $urandom_range(6000, 1000));
    write_reg(imtsm_pkg::REG_MOTION_MARGIN, $urandom_range(600, 1));
    write_reg(imtsm_pkg::REG_MOTION_HOLD, $urandom_range(8, 2));
    write_reg(imtsm_pkg::REG_SAFE_LIMIT, $urandom_range(12, 5));
    write_reg(imtsm_pkg::REG_TILT_TAN_SQ, $urandom_range(30000, 3000));
    sender_idle_pct = 33;
    recv_stall_pct = 33;
    add_random(103);
    // sender pauses until all status beats are back
    wait_drained();
    add_random(103);
    wait_drained();

    write_reg(imtsm_pkg::REG_SHOCK_THRESHOLD, $urandom_range(MAG_MAX));
    write_reg(imtsm_pkg::REG_MOTION_MARGIN, $urandom_range(2000));
    write_reg(imtsm_pkg::REG_MOTION_HOLD, $urandom_range(20, 1));
    write_reg(imtsm_pkg::REG_SAFE_LIMIT, $urandom_range(20, 5));
    write_reg(imtsm_pkg::REG_TILT_TAN_SQ, $urandom_range(TAN_MAX));
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    holdoffs_asked++;
    add_random(206);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && status_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
